>>> rtl/rtsk_pkg.sv
`timescale 1ns / 1ps

package rtsk_pkg;

    localparam int TASKS_DEF       = 16;
    localparam int SEMAPHORES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 8;

    // held semaphore field wide enough for "none" at the largest semaphore count
    localparam int HELD_W = 5;

    // request codes
    localparam logic [3:0] OP_SCHED   = 4'd0;
    localparam logic [3:0] OP_TICK    = 4'd1;
    localparam logic [3:0] OP_YIELD   = 4'd2;
    localparam logic [3:0] OP_SLEEP   = 4'd3;
    localparam logic [3:0] OP_WAIT    = 4'd4;
    localparam logic [3:0] OP_POST    = 4'd5;
    localparam logic [3:0] OP_CREATE  = 4'd6;
    localparam logic [3:0] OP_DESTROY = 4'd7;
    localparam logic [3:0] OP_SEMMAKE = 4'd8;

    // status codes
    localparam logic [2:0] STS_NONE     = 3'd0;
    localparam logic [2:0] STS_FULL     = 3'd1;
    localparam logic [2:0] STS_DUP      = 3'd2;
    localparam logic [2:0] STS_NOTFOUND = 3'd3;
    localparam logic [2:0] STS_QFULL    = 3'd4;
    localparam logic [2:0] STS_NOREADY  = 3'd5;
    localparam logic [2:0] STS_BADSEM   = 3'd6;

    // task states
    localparam logic [2:0] TS_NONE    = 3'd0;
    localparam logic [2:0] TS_UNRUN   = 3'd1;
    localparam logic [2:0] TS_READY   = 3'd2;
    localparam logic [2:0] TS_BLOCKED = 3'd3;
    localparam logic [2:0] TS_DELAYED = 3'd4;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_SKIP    = 2'd0;
    localparam logic [1:0] CFG_PREEMPT = 2'd1;
    localparam logic [1:0] CFG_INHERIT = 2'd2;

    typedef struct packed {
        logic skip_on;
        logic preempt_on;
        logic inherit_on;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] entry_id;
        logic [31:0] sleep_ticks;
        logic [3:0]  priority_req;
        logic [2:0]  semaphore_index;
        logic [15:0] initial_count;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] task_slot;
        logic [2:0] semaphore_slot;
        logic       pend_switch;
        logic [2:0] status;
    } res_t;

    typedef struct packed {
        logic [2:0]        state;
        logic [31:0]       ident;
        logic [3:0]        base_pri;
        logic [3:0]        run_pri;
        logic [3:0]        skip;
        logic [31:0]       ticks;
        logic [HELD_W-1:0] held;
    } task_rec_t;

endpackage

>>> rtl/rtos_task_scheduler_kernel.sv
`timescale 1ns / 1ps
// Kernel request engine: task table and counting semaphores with wait queues.
// Requests arrive on the s_ stream (op in s_tuser, arguments in s_tdata); one
// result transaction per request leaves on the m_ stream.
// Configuration (skip, preemption, inheritance) is to be written on the cfg_ port only
// while the block is idle (the block does not enforce this); writes take effect at once.
// One request is worked at a time. The task table sits in a memory with one read
// and one write port, read one entry per cycle, so table passes set the cost.
// Work per request:
//   semaphore create, bad semaphore, full table, destroy of id 0, unknown op : no table pass
//   yield, sleep, wait that needs no inheritance pass : read of the current task's entry
//   tick, create, destroy of an unknown id, schedule with nothing ready     : one table pass
//   wait with inheritance pass, post without waiters : current entry, then one table pass
//   post with waiters : current entry, queue compaction, woken entry, table pass
//   schedule          : readiness pass, then skip scan of at most 17*TASKS entries
//   destroy           : table pass, then compaction of every semaphore queue
// The next request can be taken in the cycle m_tvalid rises. A result is held in the
// output register while the receiver stalls; a later result waits in the engine.
// Synchronous active-low reset empties the task table (per-entry valid bits),
// clears queue lengths and counts, no clearing pass.
module rtos_task_scheduler_kernel #(
    parameter int TASKS       = rtsk_pkg::TASKS_DEF,
    parameter int SEMAPHORES  = rtsk_pkg::SEMAPHORES_DEF,
    parameter int QUEUE_DEPTH = rtsk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // entry_id[31:0], sleep_ticks[63:32], priority_req[67:64],
    // semaphore_index[70:68], initial_count[86:71], zero pad [87]
    input  logic [87:0] s_tdata,
    input  logic [3:0]  s_tuser,   // op[3:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    // ok[0], task_slot[4:1], semaphore_slot[7:5], pend_switch[8], status[11:9], pad
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_wr_data
);

    localparam int TW  = $clog2(TASKS);
    localparam int SIW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    rtsk_pkg::cfg_t      cfg_reg;
    rtsk_pkg::req_t      req;
    rtsk_pkg::res_t      res, out_reg;
    logic                res_valid, res_ready, m_tvalid_reg;
    logic [TW-1:0]       t_raddr, t_waddr;
    rtsk_pkg::task_rec_t t_rdata, t_wdata;
    logic                t_we, q_we;
    logic [SIW+QAW-1:0]  q_raddr, q_waddr;
    logic [TW-1:0]       q_rdata, q_wdata;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{skip_on: 1'b0, preempt_on: 1'b0, inherit_on: 1'b1};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rtsk_pkg::CFG_SKIP:    cfg_reg.skip_on    <= cfg_wr_data;
                rtsk_pkg::CFG_PREEMPT: cfg_reg.preempt_on <= cfg_wr_data;
                rtsk_pkg::CFG_INHERIT: cfg_reg.inherit_on <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // unpack request
    assign req = '{op: s_tuser, entry_id: s_tdata[31:0], sleep_ticks: s_tdata[63:32],
                   priority_req: s_tdata[67:64], semaphore_index: s_tdata[70:68],
                   initial_count: s_tdata[86:71]};

    rtsk_ctrl #(.TASKS(TASKS), .SEMAPHORES(SEMAPHORES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .req_valid(s_tvalid), .req_ready(s_tready), .req(req),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .t_raddr(t_raddr), .t_rdata(t_rdata), .t_we(t_we), .t_waddr(t_waddr),
        .t_wdata(t_wdata),
        .q_raddr(q_raddr), .q_rdata(q_rdata), .q_we(q_we), .q_waddr(q_waddr),
        .q_wdata(q_wdata)
    );

    rtsk_ram #(.WIDTH($bits(rtsk_pkg::task_rec_t)), .DEPTH(TASKS)) u_task_ram (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    rtsk_ram #(.WIDTH(TW), .DEPTH(SEMAPHORES << QAW)) u_queue_ram (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
            if (res_valid) out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_reg.status, out_reg.pend_switch, out_reg.semaphore_slot,
                       out_reg.task_slot, out_reg.ok};

endmodule

>>> rtl/rtsk_ram.sv
`timescale 1ns / 1ps

module rtsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> rtl/rtsk_ctrl.sv
`timescale 1ns / 1ps

module rtsk_ctrl #(
    parameter int TASKS       = rtsk_pkg::TASKS_DEF,
    parameter int SEMAPHORES  = rtsk_pkg::SEMAPHORES_DEF,
    parameter int QUEUE_DEPTH = rtsk_pkg::QUEUE_DEPTH_DEF,
    localparam int TW  = $clog2(TASKS),
    localparam int SIW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1,
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rtsk_pkg::cfg_t        cfg,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  rtsk_pkg::req_t        req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output rtsk_pkg::res_t        res,
    // task table memory
    output logic [TW-1:0]         t_raddr,
    input  rtsk_pkg::task_rec_t   t_rdata,
    output logic                  t_we,
    output logic [TW-1:0]         t_waddr,
    output rtsk_pkg::task_rec_t   t_wdata,
    // wait queue memory
    output logic [SIW+QAW-1:0]    q_raddr,
    input  logic [TW-1:0]         q_rdata,
    output logic                  q_we,
    output logic [SIW+QAW-1:0]    q_waddr,
    output logic [TW-1:0]         q_wdata
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(SEMAPHORES + 1);
    localparam int NW = $clog2(TASKS + 1);
    localparam int KW = $clog2(17 * TASKS + 1);
    localparam logic [rtsk_pkg::HELD_W-1:0] NO_SEM = rtsk_pkg::HELD_W'(SEMAPHORES);

    typedef enum logic [1:0] {S_IDLE, S_PASS, S_QUEUE, S_DONE} state_t;
    typedef enum logic [3:0] {
        PH_ANY, PH_SCHED, PH_TICK, PH_CUR, PH_INH, PH_REBASE,
        PH_CREATE, PH_DESTROY, PH_WAKE
    } phase_t;
    typedef enum logic [1:0] {NX_DONE, NX_INH, NX_QUEUE, NX_REBASE} next_t;

    state_t         state_reg;
    phase_t         phase_reg;
    next_t          nx_reg;
    rtsk_pkg::req_t req_reg;
    rtsk_pkg::res_t res_reg;

    logic [TW-1:0]  cur_reg, scan_reg;
    logic [NW-1:0]  live_reg;
    logic [CW-1:0]  sems_reg;
    logic [TASKS-1:0] valid_reg;
    logic [15:0]    sem_val_reg [SEMAPHORES];
    logic [LW-1:0]  sem_len_reg [SEMAPHORES];

    // table pass engine
    logic [TW-1:0]  addr_reg, paddr_reg, slot_reg;
    logic [KW-1:0]  left_reg;
    logic           pv_reg, rv_reg, flag_reg, free_reg;
    logic [3:0]     run_cur_reg;

    // queue compaction engine
    logic [SIW-1:0] qs_reg;
    logic [QAW-1:0] rk_reg;
    logic [LW-1:0]  rleft_reg, n_reg;
    logic           qpv_reg, qpk0_reg, qdrop_reg;

    rtsk_pkg::task_rec_t rec, wrec;
    logic           run_ok, pick, pass_end, q_end, s_ok, q_keep;
    logic [SIW-1:0] sidx, sidx_in;
    logic [15:0]    sval;
    logic [LW-1:0]  slen;

    assign sidx    = SIW'(req_reg.semaphore_index);
    assign sidx_in = SIW'(req.semaphore_index);
    assign sval    = sem_val_reg[sidx];
    assign slen    = sem_len_reg[sidx];
    assign s_ok    = 8'(req.semaphore_index) < 8'(sems_reg);

    // entries never written read as their reset value
    always_comb begin
        if (rv_reg) begin
            rec = t_rdata;
        end else begin
            rec = '{state: rtsk_pkg::TS_NONE, ident: '0, base_pri: '0, run_pri: '0,
                    skip: '0, ticks: '0, held: NO_SEM};
        end
    end

    assign run_ok   = (rec.state == rtsk_pkg::TS_UNRUN) || (rec.state == rtsk_pkg::TS_READY);
    assign pass_end = (state_reg == S_PASS) && (left_reg == '0) && !pv_reg;
    assign q_end    = (state_reg == S_QUEUE) && (rleft_reg == '0) && !qpv_reg;
    assign q_keep   = qdrop_reg ? !qpk0_reg : (q_rdata != slot_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign t_raddr   = addr_reg;
    assign q_raddr   = {qs_reg, rk_reg};

    // read-modify-write of the entry returned by the table memory
    always_comb begin
        wrec    = rec;
        t_we    = 1'b0;
        t_waddr = paddr_reg;
        pick    = 1'b0;
        q_we    = 1'b0;
        q_waddr = {qs_reg, n_reg[QAW-1:0]};
        q_wdata = q_rdata;
        if (state_reg == S_PASS && pv_reg) begin
            case (phase_reg)
                PH_SCHED: begin
                    if (run_ok) begin
                        t_we = 1'b1;
                        if (!cfg.skip_on || rec.skip == 4'd0) begin
                            pick = 1'b1;
                            if (cfg.skip_on) wrec.skip = rec.run_pri;
                            if (rec.state == rtsk_pkg::TS_UNRUN) wrec.state = rtsk_pkg::TS_READY;
                        end else begin
                            wrec.skip = rec.skip - 4'd1;
                        end
                    end
                end
                PH_TICK: begin
                    if (rec.state == rtsk_pkg::TS_DELAYED) begin
                        t_we = 1'b1;
                        if (rec.ticks <= 32'd1) begin
                            wrec.ticks = '0;
                            wrec.state = rtsk_pkg::TS_READY;
                        end else begin
                            wrec.ticks = rec.ticks - 32'd1;
                        end
                    end
                end
                PH_CUR: begin
                    case (req_reg.op)
                        rtsk_pkg::OP_YIELD: begin
                            t_we = run_ok;
                            wrec.state = rtsk_pkg::TS_READY;
                        end
                        rtsk_pkg::OP_SLEEP: begin
                            t_we = run_ok;
                            wrec.state = rtsk_pkg::TS_DELAYED;
                            wrec.ticks = (req_reg.sleep_ticks == '0) ? 32'd1
                                                                      : req_reg.sleep_ticks;
                        end
                        rtsk_pkg::OP_WAIT: begin
                            if (run_ok && sval != '0) begin
                                t_we = 1'b1;
                                wrec.held = rtsk_pkg::HELD_W'(sidx);
                            end else if (run_ok && 32'(slen) < 32'(QUEUE_DEPTH)) begin
                                t_we = 1'b1;
                                wrec.state = rtsk_pkg::TS_BLOCKED;
                                q_we = 1'b1;
                                q_waddr = {sidx, slen[QAW-1:0]};
                                q_wdata = paddr_reg;
                            end
                        end
                        rtsk_pkg::OP_POST: begin
                            t_we = 1'b1;
                            wrec.held = NO_SEM;
                            if (rec.state != rtsk_pkg::TS_NONE) wrec.run_pri = rec.base_pri;
                        end
                        default: ;
                    endcase
                end
                PH_WAKE: begin
                    t_we = 1'b1;
                    wrec.state = rtsk_pkg::TS_READY;
                    wrec.held = rtsk_pkg::HELD_W'(sidx);
                end
                PH_INH: begin
                    if (rec.held == rtsk_pkg::HELD_W'(sidx) && rec.state != rtsk_pkg::TS_NONE &&
                        rec.state != rtsk_pkg::TS_BLOCKED && rec.run_pri > run_cur_reg) begin
                        t_we = 1'b1;
                        wrec.run_pri = run_cur_reg;
                    end
                end
                PH_REBASE: begin
                    if (rec.held == rtsk_pkg::HELD_W'(sidx) && rec.state != rtsk_pkg::TS_NONE) begin
                        t_we = 1'b1;
                        wrec.run_pri = rec.base_pri;
                    end
                end
                PH_DESTROY: begin
                    if (rec.state != rtsk_pkg::TS_NONE && rec.ident == req_reg.entry_id) begin
                        t_we = 1'b1;
                        wrec.state = rtsk_pkg::TS_NONE;
                        wrec.ident = '0;
                        wrec.held = NO_SEM;
                    end
                end
                default: ;
            endcase
        end
        // new task goes into the first free slot once the table pass is over
        if (pass_end && phase_reg == PH_CREATE && !flag_reg && free_reg) begin
            t_we    = 1'b1;
            t_waddr = slot_reg;
            wrec    = '{state: rtsk_pkg::TS_UNRUN, ident: req_reg.entry_id,
                        base_pri: req_reg.priority_req, run_pri: req_reg.priority_req,
                        skip: '0, ticks: '0, held: NO_SEM};
        end
        // queue compaction write-back
        if (state_reg == S_QUEUE && qpv_reg && q_keep) begin
            q_we    = 1'b1;
            q_waddr = {qs_reg, n_reg[QAW-1:0]};
            q_wdata = q_rdata;
        end
        t_wdata = wrec;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_ANY;
            nx_reg    <= NX_DONE;
            cur_reg   <= '0;
            scan_reg  <= TW'(TASKS - 1);
            live_reg  <= '0;
            sems_reg  <= '0;
            valid_reg <= '0;
            pv_reg    <= 1'b0;
            qpv_reg   <= 1'b0;
            left_reg  <= '0;
            rleft_reg <= '0;
            for (int i = 0; i < SEMAPHORES; i++) sem_len_reg[i] <= '0;
        end else begin
            if (t_we) valid_reg[t_waddr] <= 1'b1;
            case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        req_reg   <= req;
                        res_reg   <= '0;
                        nx_reg    <= NX_DONE;
                        flag_reg  <= 1'b0;
                        free_reg  <= 1'b0;
                        addr_reg  <= '0;
                        left_reg  <= KW'(TASKS);
                        state_reg <= S_PASS;
                        case (req.op)
                            rtsk_pkg::OP_SCHED: phase_reg <= PH_ANY;
                            rtsk_pkg::OP_TICK: begin
                                phase_reg <= PH_TICK;
                                res_reg.ok <= 1'b1;
                                res_reg.pend_switch <= cfg.preempt_on;
                            end
                            rtsk_pkg::OP_YIELD, rtsk_pkg::OP_SLEEP: begin
                                phase_reg <= PH_CUR;
                                addr_reg <= cur_reg;
                                left_reg <= KW'(1);
                                res_reg.pend_switch <= 1'b1;
                            end
                            rtsk_pkg::OP_WAIT, rtsk_pkg::OP_POST: begin
                                phase_reg <= PH_CUR;
                                addr_reg <= cur_reg;
                                left_reg <= KW'(1);
                                res_reg.pend_switch <= 1'b1;
                                if (!s_ok) begin
                                    res_reg.status <= rtsk_pkg::STS_BADSEM;
                                    state_reg <= S_DONE;
                                end
                            end
                            rtsk_pkg::OP_CREATE: begin
                                phase_reg <= PH_CREATE;
                                flag_reg <= (req.entry_id == '0);
                                if (live_reg >= NW'(TASKS)) begin
                                    res_reg.status <= rtsk_pkg::STS_FULL;
                                    state_reg <= S_DONE;
                                end
                            end
                            rtsk_pkg::OP_DESTROY: begin
                                phase_reg <= PH_DESTROY;
                                res_reg.pend_switch <= 1'b1;
                                res_reg.status <= rtsk_pkg::STS_NOTFOUND;
                                if (req.entry_id == '0) state_reg <= S_DONE;
                            end
                            rtsk_pkg::OP_SEMMAKE: begin
                                state_reg <= S_DONE;
                                if (sems_reg >= CW'(SEMAPHORES)) begin
                                    res_reg.status <= rtsk_pkg::STS_FULL;
                                end else begin
                                    res_reg.ok <= 1'b1;
                                    res_reg.semaphore_slot <= 3'(sems_reg);
                                    sem_val_reg[SIW'(sems_reg)] <= req.initial_count;
                                    sem_len_reg[SIW'(sems_reg)] <= '0;
                                    sems_reg <= sems_reg + 1'b1;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                        if (req.op == rtsk_pkg::OP_WAIT || req.op == rtsk_pkg::OP_POST) begin
                            qs_reg <= sidx_in;
                        end
                    end
                end

                S_PASS: begin
                    // issue the next table read
                    if (left_reg != '0) begin
                        addr_reg  <= (addr_reg == TW'(TASKS - 1)) ? '0 : addr_reg + 1'b1;
                        left_reg  <= left_reg - 1'b1;
                        pv_reg    <= 1'b1;
                        paddr_reg <= addr_reg;
                        rv_reg    <= valid_reg[addr_reg];
                    end else begin
                        pv_reg <= 1'b0;
                    end
                    // act on the returned entry
                    if (pv_reg) begin
                        case (phase_reg)
                            PH_ANY: if (run_ok) flag_reg <= 1'b1;
                            PH_SCHED: begin
                                if (pick) begin
                                    cur_reg  <= paddr_reg;
                                    scan_reg <= paddr_reg;
                                    res_reg.ok <= 1'b1;
                                    res_reg.task_slot <= 4'(paddr_reg);
                                    left_reg <= '0;
                                    pv_reg   <= 1'b0;
                                end
                            end
                            PH_CUR: begin
                                case (req_reg.op)
                                    rtsk_pkg::OP_YIELD, rtsk_pkg::OP_SLEEP: begin
                                        if (run_ok) res_reg.ok <= 1'b1;
                                        else res_reg.status <= rtsk_pkg::STS_NOTFOUND;
                                    end
                                    rtsk_pkg::OP_WAIT: begin
                                        if (!run_ok) begin
                                            res_reg.status <= rtsk_pkg::STS_NOTFOUND;
                                        end else if (sval != '0) begin
                                            sem_val_reg[sidx] <= sval - 16'd1;
                                            res_reg.ok <= 1'b1;
                                        end else if (32'(slen) >= 32'(QUEUE_DEPTH)) begin
                                            res_reg.status <= rtsk_pkg::STS_QFULL;
                                        end else begin
                                            sem_len_reg[sidx] <= slen + 1'b1;
                                            res_reg.ok <= 1'b1;
                                            run_cur_reg <= rec.run_pri;
                                            if (cfg.inherit_on) nx_reg <= NX_INH;
                                        end
                                    end
                                    rtsk_pkg::OP_POST: begin
                                        res_reg.ok <= 1'b1;
                                        if (slen != '0) begin
                                            nx_reg <= NX_QUEUE;
                                        end else begin
                                            nx_reg <= NX_REBASE;
                                            if (sval != rtsk_pkg::COUNT_MAX) begin
                                                sem_val_reg[sidx] <= sval + 16'd1;
                                            end
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            PH_CREATE: begin
                                if (rec.state != rtsk_pkg::TS_NONE &&
                                    rec.ident == req_reg.entry_id) flag_reg <= 1'b1;
                                if (rec.state == rtsk_pkg::TS_NONE && !free_reg) begin
                                    free_reg <= 1'b1;
                                    slot_reg <= paddr_reg;
                                end
                            end
                            PH_DESTROY: begin
                                if (t_we) begin
                                    flag_reg <= 1'b1;
                                    slot_reg <= paddr_reg;
                                    if (live_reg != '0) live_reg <= live_reg - 1'b1;
                                    res_reg.ok <= 1'b1;
                                    res_reg.status <= rtsk_pkg::STS_NONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                    // pass over: choose what follows
                    if (pass_end) begin
                        case (phase_reg)
                            PH_ANY: begin
                                if (flag_reg) begin
                                    phase_reg <= PH_SCHED;
                                    addr_reg  <= (scan_reg == TW'(TASKS - 1)) ? '0
                                                                             : scan_reg + 1'b1;
                                    left_reg  <= KW'(17 * TASKS);
                                end else begin
                                    res_reg.status <= rtsk_pkg::STS_NOREADY;
                                    state_reg <= S_DONE;
                                end
                            end
                            PH_CUR: begin
                                case (nx_reg)
                                    NX_INH: begin
                                        phase_reg <= PH_INH;
                                        addr_reg  <= '0;
                                        left_reg  <= KW'(TASKS);
                                    end
                                    NX_REBASE: begin
                                        phase_reg <= PH_REBASE;
                                        addr_reg  <= '0;
                                        left_reg  <= KW'(TASKS);
                                    end
                                    NX_QUEUE: begin
                                        state_reg <= S_QUEUE;
                                        qdrop_reg <= 1'b1;
                                        qs_reg    <= sidx;
                                        rk_reg    <= '0;
                                        rleft_reg <= slen;
                                        n_reg     <= '0;
                                    end
                                    default: state_reg <= S_DONE;
                                endcase
                            end
                            PH_WAKE: begin
                                phase_reg <= PH_REBASE;
                                addr_reg  <= '0;
                                left_reg  <= KW'(TASKS);
                            end
                            PH_CREATE: begin
                                state_reg <= S_DONE;
                                if (flag_reg) begin
                                    res_reg.status <= rtsk_pkg::STS_DUP;
                                end else if (!free_reg) begin
                                    res_reg.status <= rtsk_pkg::STS_FULL;
                                end else begin
                                    live_reg <= live_reg + 1'b1;
                                    res_reg.ok <= 1'b1;
                                    res_reg.task_slot <= 4'(slot_reg);
                                end
                            end
                            PH_DESTROY: begin
                                if (flag_reg) begin
                                    state_reg <= S_QUEUE;
                                    qdrop_reg <= 1'b0;
                                    qs_reg    <= '0;
                                    rk_reg    <= '0;
                                    rleft_reg <= sem_len_reg[0];
                                    n_reg     <= '0;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end

                S_QUEUE: begin
                    if (rleft_reg != '0) begin
                        rk_reg    <= rk_reg + 1'b1;
                        rleft_reg <= rleft_reg - 1'b1;
                        qpv_reg   <= 1'b1;
                        qpk0_reg  <= (rk_reg == '0);
                    end else begin
                        qpv_reg <= 1'b0;
                    end
                    if (qpv_reg) begin
                        if (qdrop_reg && qpk0_reg) slot_reg <= q_rdata;
                        if (q_keep) n_reg <= n_reg + 1'b1;
                    end
                    if (q_end) begin
                        sem_len_reg[qs_reg] <= n_reg;
                        if (qdrop_reg) begin
                            state_reg <= S_PASS;
                            phase_reg <= PH_WAKE;
                            addr_reg  <= slot_reg;
                            left_reg  <= KW'(1);
                        end else if (qs_reg == SIW'(SEMAPHORES - 1)) begin
                            state_reg <= S_DONE;
                        end else begin
                            qs_reg    <= qs_reg + 1'b1;
                            rk_reg    <= '0;
                            rleft_reg <= sem_len_reg[qs_reg + 1'b1];
                            n_reg     <= '0;
                        end
                    end
                end

                S_DONE: begin
                    if (res_ready) state_reg <= S_IDLE;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/rtsk_checker.sv
`timescale 1ns / 1ps

module rtsk_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    logic [1:0] open_reg;

    // requests taken but results not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_reg + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_reg != 2'd0)
        else $error("result without request");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= 2'd2)
        else $error("too many requests in flight");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

endmodule

bind rtos_task_scheduler_kernel rtsk_checker u_rtsk_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
);

>>> bench/rtos_task_scheduler_kernel_chk.sv
`timescale 1ns / 1ps

module rtos_task_scheduler_kernel_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [87:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_wr_data,
    output int          fail_count,
    output int          pending_results
);

    localparam int NT = 16;
    localparam int NS = 8;
    localparam int QD = 8;
    localparam logic [3:0] SEM_NONE = 4'd8;

    // shadow configuration
    logic skip_on, preempt_on, inherit_on;

    // shadow kernel tables
    logic [2:0]  tstate [NT];
    logic [31:0] tident [NT];
    logic [3:0]  bpri   [NT];
    logic [3:0]  rpri   [NT];
    logic [3:0]  skipc  [NT];
    logic [31:0] ticks  [NT];
    logic [3:0]  held   [NT];
    int          cur_task, scan_pos, live_cnt, sem_cnt;
    logic [15:0] sval   [NS];
    logic [3:0]  squeue [NS][QD];
    int          qlen   [NS];

    rtsk_pkg::res_t expected_q[$];

    function automatic bit is_runnable(int t);
        return tstate[t] == rtsk_pkg::TS_UNRUN || tstate[t] == rtsk_pkg::TS_READY;
    endfunction

    function automatic void drop_from_queues(logic [3:0] t);
        int n;
        for (int s = 0; s < NS; s++) begin
            n = 0;
            for (int k = 0; k < qlen[s]; k++)
                if (squeue[s][k] != t) begin
                    squeue[s][n] = squeue[s][k];
                    n++;
                end
            qlen[s] = n;
        end
    endfunction

    // apply one request to the shadow state and return its result
    function automatic rtsk_pkg::res_t kernel_outcome(rtsk_pkg::req_t rq, logic [3:0] op);
        rtsk_pkg::res_t r;
        bit any, dup;
        int t, s, w, c;
        r = '0;
        s = int'(rq.semaphore_index);
        c = cur_task;
        case (op)
            rtsk_pkg::OP_SCHED: begin
                any = 0;
                for (int i = 0; i < NT; i++) if (is_runnable(i)) any = 1;
                if (!any) begin
                    r.status = rtsk_pkg::STS_NOREADY;
                end else begin
                    t = scan_pos;
                    for (int k = 0; k < 17 * NT; k++) begin
                        t = (t + 1 >= NT) ? 0 : t + 1;
                        if (!is_runnable(t)) continue;
                        if (!skip_on) break;
                        if (skipc[t] == 4'd0) begin
                            skipc[t] = rpri[t];
                            break;
                        end
                        skipc[t]--;
                    end
                    scan_pos = t;
                    cur_task = t;
                    if (tstate[t] == rtsk_pkg::TS_UNRUN) tstate[t] = rtsk_pkg::TS_READY;
                    r.ok = 1'b1;
                    r.task_slot = 4'(t);
                end
            end
            rtsk_pkg::OP_TICK: begin
                for (int i = 0; i < NT; i++)
                    if (tstate[i] == rtsk_pkg::TS_DELAYED) begin
                        if (ticks[i] <= 32'd1) begin
                            ticks[i] = '0;
                            tstate[i] = rtsk_pkg::TS_READY;
                        end else ticks[i]--;
                    end
                r.ok = 1'b1;
                r.pend_switch = preempt_on;
            end
            rtsk_pkg::OP_YIELD: begin
                r.pend_switch = 1'b1;
                if (!is_runnable(c)) r.status = rtsk_pkg::STS_NOTFOUND;
                else begin
                    tstate[c] = rtsk_pkg::TS_READY;
                    r.ok = 1'b1;
                end
            end
            rtsk_pkg::OP_SLEEP: begin
                r.pend_switch = 1'b1;
                if (!is_runnable(c)) r.status = rtsk_pkg::STS_NOTFOUND;
                else begin
                    ticks[c] = (rq.sleep_ticks == '0) ? 32'd1 : rq.sleep_ticks;
                    tstate[c] = rtsk_pkg::TS_DELAYED;
                    r.ok = 1'b1;
                end
            end
            rtsk_pkg::OP_WAIT: begin
                r.pend_switch = 1'b1;
                if (s >= sem_cnt) r.status = rtsk_pkg::STS_BADSEM;
                else if (!is_runnable(c)) r.status = rtsk_pkg::STS_NOTFOUND;
                else if (sval[s] != '0) begin
                    sval[s]--;
                    held[c] = 4'(s);
                    r.ok = 1'b1;
                end else if (qlen[s] >= QD) r.status = rtsk_pkg::STS_QFULL;
                else begin
                    squeue[s][qlen[s]] = 4'(c);
                    qlen[s]++;
                    tstate[c] = rtsk_pkg::TS_BLOCKED;
                    if (inherit_on)
                        for (int i = 0; i < NT; i++)
                            if (held[i] == 4'(s) && tstate[i] != rtsk_pkg::TS_NONE &&
                                tstate[i] != rtsk_pkg::TS_BLOCKED && rpri[i] > rpri[c])
                                rpri[i] = rpri[c];
                    r.ok = 1'b1;
                end
            end
            rtsk_pkg::OP_POST: begin
                r.pend_switch = 1'b1;
                if (s >= sem_cnt) r.status = rtsk_pkg::STS_BADSEM;
                else begin
                    held[c] = SEM_NONE;
                    if (tstate[c] != rtsk_pkg::TS_NONE) rpri[c] = bpri[c];
                    if (qlen[s] > 0) begin
                        w = int'(squeue[s][0]);
                        for (int k = 0; k < qlen[s] - 1; k++)
                            squeue[s][k] = squeue[s][k + 1];
                        qlen[s]--;
                        tstate[w] = rtsk_pkg::TS_READY;
                        held[w] = 4'(s);
                    end else if (sval[s] != rtsk_pkg::COUNT_MAX) sval[s]++;
                    for (int i = 0; i < NT; i++)
                        if (held[i] == 4'(s) && tstate[i] != rtsk_pkg::TS_NONE)
                            rpri[i] = bpri[i];
                    r.ok = 1'b1;
                end
            end
            rtsk_pkg::OP_CREATE: begin
                dup = (rq.entry_id == '0);
                if (live_cnt >= NT) r.status = rtsk_pkg::STS_FULL;
                else begin
                    for (int i = 0; i < NT; i++)
                        if (tstate[i] != rtsk_pkg::TS_NONE && tident[i] == rq.entry_id)
                            dup = 1;
                    if (dup) r.status = rtsk_pkg::STS_DUP;
                    else begin
                        t = 0;
                        while (t < NT && tstate[t] != rtsk_pkg::TS_NONE) t++;
                        tstate[t] = rtsk_pkg::TS_UNRUN;
                        tident[t] = rq.entry_id;
                        bpri[t] = rq.priority_req;
                        rpri[t] = rq.priority_req;
                        skipc[t] = '0;
                        ticks[t] = '0;
                        held[t] = SEM_NONE;
                        live_cnt++;
                        r.ok = 1'b1;
                        r.task_slot = 4'(t);
                    end
                end
            end
            rtsk_pkg::OP_DESTROY: begin
                r.pend_switch = 1'b1;
                r.status = rtsk_pkg::STS_NOTFOUND;
                if (rq.entry_id != '0)
                    for (int i = 0; i < NT; i++)
                        if (tstate[i] != rtsk_pkg::TS_NONE && tident[i] == rq.entry_id) begin
                            tstate[i] = rtsk_pkg::TS_NONE;
                            tident[i] = '0;
                            held[i] = SEM_NONE;
                            drop_from_queues(4'(i));
                            if (live_cnt > 0) live_cnt--;
                            r.ok = 1'b1;
                            r.status = rtsk_pkg::STS_NONE;
                        end
            end
            rtsk_pkg::OP_SEMMAKE: begin
                if (sem_cnt >= NS) r.status = rtsk_pkg::STS_FULL;
                else begin
                    r.semaphore_slot = 3'(sem_cnt);
                    sval[sem_cnt] = rq.initial_count;
                    qlen[sem_cnt] = 0;
                    sem_cnt++;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // track requests, configuration and results
    always @(posedge aclk) begin
        rtsk_pkg::res_t got, want;
        rtsk_pkg::req_t rq;
        if (!aresetn) begin
            skip_on = 1'b0; preempt_on = 1'b0; inherit_on = 1'b1;
            for (int i = 0; i < NT; i++) begin
                tstate[i] = rtsk_pkg::TS_NONE; tident[i] = '0; skipc[i] = '0;
                held[i] = SEM_NONE; bpri[i] = '0; rpri[i] = '0; ticks[i] = '0;
            end
            for (int s = 0; s < NS; s++) begin
                qlen[s] = 0;
                sval[s] = '0;
            end
            cur_task = 0; scan_pos = NT - 1; live_cnt = 0; sem_cnt = 0;
            expected_q.delete();
            fail_count = 0;
            pending_results = 0;
        end else begin
            if (cfg_wr_en)
                case (cfg_index)
                    rtsk_pkg::CFG_SKIP:    skip_on = cfg_wr_data;
                    rtsk_pkg::CFG_PREEMPT: preempt_on = cfg_wr_data;
                    rtsk_pkg::CFG_INHERIT: inherit_on = cfg_wr_data;
                    default: ;
                endcase
            if (m_tvalid && m_tready) begin
                got.ok = m_tdata[0];
                got.task_slot = m_tdata[4:1];
                got.semaphore_slot = m_tdata[7:5];
                got.pend_switch = m_tdata[8];
                got.status = m_tdata[11:9];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result transaction", int'(m_tdata), -1);
                end else begin
                    want = expected_q.pop_front();
                    if (got.ok != want.ok)
                        report_mismatch("ok", int'(got.ok), int'(want.ok));
                    if (got.task_slot != want.task_slot)
                        report_mismatch("task_slot", int'(got.task_slot),
                                        int'(want.task_slot));
                    if (got.semaphore_slot != want.semaphore_slot)
                        report_mismatch("semaphore_slot", int'(got.semaphore_slot),
                                        int'(want.semaphore_slot));
                    if (got.pend_switch != want.pend_switch)
                        report_mismatch("pend_switch", int'(got.pend_switch),
                                        int'(want.pend_switch));
                    if (got.status != want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                rq.op = s_tuser;
                rq.entry_id = s_tdata[31:0];
                rq.sleep_ticks = s_tdata[63:32];
                rq.priority_req = s_tdata[67:64];
                rq.semaphore_index = s_tdata[70:68];
                rq.initial_count = s_tdata[86:71];
                expected_q.push_back(kernel_outcome(rq, s_tuser));
            end
            pending_results = expected_q.size();
        end
    end

endmodule

>>> bench/rtos_task_scheduler_kernel_tb.sv
`timescale 1ns / 1ps

module rtos_task_scheduler_kernel_tb;

    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic [87:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic        cfg_wr_data;
    int          fail_count;
    int          pending_results;
    int          quiet_cycles;

    // ids of the last 40 create requests, so destroys and duplicates hit real tasks
    logic [31:0] known_ids[$];

    rtos_task_scheduler_kernel dut (.*);

    rtos_task_scheduler_kernel_chk chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    initial begin
        int g;
        m_tready = 0;
        @(posedge aclk);
        forever begin
            g = gap_len();
            if (g == 0) m_tready <= 1;
            else begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
                m_tready <= 1;
            end
            @(posedge aclk);
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid stays high after a transaction unless a gap follows
    task automatic send_req(logic [3:0] op, logic [31:0] id, logic [31:0] slp,
                            logic [3:0] pri, logic [2:0] sem, logic [15:0] cnt);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {1'b0, cnt, sem, pri, slp, id};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic v);
        cfg_wr_en   <= 1;
        cfg_index   <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_id();
        if (known_ids.size() != 0 && $urandom_range(0, 3) != 0)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        return $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 40);
    endfunction

    // weighted random kernel request, mostly well-formed
    task automatic random_req();
        int p;
        logic [31:0] id, slp;
        p = $urandom_range(0, 99);
        slp = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
        if (p < 22) send_req(rtsk_pkg::OP_SCHED, $urandom(), $urandom(), '0, '0, '0);
        else if (p < 34) send_req(rtsk_pkg::OP_TICK, '0, '0, '0, '0, '0);
        else if (p < 40) send_req(rtsk_pkg::OP_YIELD, '0, '0, '0, '0, '0);
        else if (p < 46) send_req(rtsk_pkg::OP_SLEEP, '0, slp, '0, '0, '0);
        else if (p < 60) send_req(rtsk_pkg::OP_WAIT, '0, '0, '0, 3'($urandom()), '0);
        else if (p < 73) send_req(rtsk_pkg::OP_POST, '0, '0, '0, 3'($urandom()), '0);
        else if (p < 84) begin
            id = pick_id();
            known_ids.push_back(id);
            if (known_ids.size() > 40) void'(known_ids.pop_front());
            send_req(rtsk_pkg::OP_CREATE, id, $urandom(), 4'($urandom()), 3'($urandom()),
                     16'($urandom()));
        end else if (p < 93) send_req(rtsk_pkg::OP_DESTROY, pick_id(), '0, '0, '0, '0);
        else if (p < 97) send_req(rtsk_pkg::OP_SEMMAKE, '0, '0, '0, '0,
                                  $urandom_range(0, 1) ? 16'($urandom_range(0, 2))
                                                       : 16'($urandom()));
        else send_req(4'($urandom_range(9, 15)), $urandom(), $urandom(), 4'($urandom()),
                      3'($urandom()), 16'($urandom()));
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = '0;
        cfg_wr_en = 0; cfg_index = '0; cfg_wr_data = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty table cases, then first creates, semaphores and edge values
        send_req(rtsk_pkg::OP_SCHED, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_YIELD, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_WAIT, '0, '0, '0, 3'd7, '0);
        send_req(rtsk_pkg::OP_POST, '0, '0, '0, 3'd0, '0);
        send_req(rtsk_pkg::OP_DESTROY, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_CREATE, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_CREATE, 32'hFFFF_FFFF, '0, 4'd15, '0, '0);
        send_req(rtsk_pkg::OP_CREATE, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_CREATE, 32'd1, '0, 4'd0, '0, '0);
        send_req(rtsk_pkg::OP_SEMMAKE, '0, '0, '0, '0, 16'hFFFF);
        send_req(rtsk_pkg::OP_SEMMAKE, '0, '0, '0, '0, 16'h0000);
        send_req(rtsk_pkg::OP_POST, '0, '0, '0, 3'd0, '0);
        send_req(rtsk_pkg::OP_SCHED, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_WAIT, '0, '0, '0, 3'd1, '0);
        send_req(rtsk_pkg::OP_SCHED, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_WAIT, '0, '0, '0, 3'd1, '0);
        send_req(rtsk_pkg::OP_POST, '0, '0, '0, 3'd1, '0);
        send_req(rtsk_pkg::OP_SLEEP, '0, 32'd0, '0, '0, '0);
        send_req(rtsk_pkg::OP_TICK, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_SCHED, '0, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_SLEEP, '0, 32'hFFFF_FFFF, '0, '0, '0);
        send_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 3'h7, 16'hFFFF);
        send_req(rtsk_pkg::OP_DESTROY, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_req(rtsk_pkg::OP_DESTROY, 32'd1234, '0, '0, '0, '0);

        // random phases over several settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            write_cfg(rtsk_pkg::CFG_SKIP, ph[0]);
            write_cfg(rtsk_pkg::CFG_PREEMPT, ph[1]);
            write_cfg(rtsk_pkg::CFG_INHERIT, ~ph[2]);
            cfg_wr_en <= 0;
            repeat (190) random_req();
        end

        settle();
        if (fail_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> rtos_task_scheduler_kernel.f
rtl/rtsk_pkg.sv
rtl/rtsk_ram.sv
rtl/rtsk_ctrl.sv
rtl/rtos_task_scheduler_kernel.sv
rtl/rtsk_checker.sv
bench/rtos_task_scheduler_kernel_chk.sv
bench/rtos_task_scheduler_kernel_tb.sv
